// ===== rtl/core/mcsr_pkg.sv =====
// Shared types and constants for the midpoint circle span rasterizer.
// No dependencies; imported by every file of the block but mcsr_if.
`default_nettype none
package mcsr_pkg;

    typedef enum logic [1:0] {
        FUNC_OUTLINE = 2'd0,
        FUNC_FILL    = 2'd1,
        FUNC_STEP    = 2'd2,
        FUNC_IGNORE  = 2'd3
    } t_func;

    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_TOP    = 2'd1;
    localparam logic [1:0] CFG_RIGHT  = 2'd2;
    localparam logic [1:0] CFG_BOTTOM = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef enum logic [1:0] {
        JOB_OUTLINE = 2'd0,
        JOB_FILL    = 2'd1,
        JOB_DONE    = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic               done;
        logic signed [10:0] x;
        logic signed [10:0] y;
        logic signed [10:0] xc;
        logic signed [10:0] yc;
        logic [7:0]         color;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage
`default_nettype wire

// ===== rtl/core/mcsr_if.sv =====
// Handshake interfaces for the item and span channels.
// Depends on nothing; each carries valid, ready and the payload of one beat.
`default_nettype none
interface mcsr_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [10:0] center_col;
    logic signed [10:0] center_row;
    logic [8:0]         radius;
    logic [7:0]         color;

    modport source (output valid, func, center_col, center_row, radius, color,
                    input ready);
    modport sink   (input valid, func, center_col, center_row, radius, color,
                    output ready);
endinterface

interface mcsr_span_if;
    logic       valid;
    logic       ready;
    logic       visible;
    logic [7:0] row;
    logic [8:0] col_start;
    logic [8:0] col_end;
    logic [7:0] pix_color;
    logic       circle_done;
    logic       last;

    modport source (output valid, visible, row, col_start, col_end, pix_color,
                    circle_done, last, input ready);
    modport sink   (input valid, visible, row, col_start, col_end, pix_color,
                    circle_done, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mcsr_front.sv =====
// Front end: accepts items, holds the circle state and runs the midpoint update.
// Depends on mcsr_pkg and mcsr_item_if; pushes one job per step beat.
`default_nettype none
module mcsr_front import mcsr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mcsr_item_if.sink   i_item,
    input  wire logic   i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    logic signed [10:0] r_ctr_col, r_ctr_row, r_step_x, r_step_y;
    logic signed [13:0] r_dec;
    logic               r_fill;
    logic [7:0]         r_color;

    logic signed [10:0] n_ctr_col, n_ctr_row, n_step_x, n_step_y;
    logic signed [13:0] n_dec;
    logic               n_fill;
    logic [7:0]         n_color;

    logic               accept;
    logic               ended;
    t_func              func;

    assign i_item.ready = !i_q_full;
    assign accept       = i_item.valid && !i_q_full;
    assign func         = t_func'(i_item.func);
    assign ended        = r_step_x > r_step_y;

    always_comb begin
        n_ctr_col = r_ctr_col;
        n_ctr_row = r_ctr_row;
        n_step_x  = r_step_x;
        n_step_y  = r_step_y;
        n_dec     = r_dec;
        n_fill    = r_fill;
        n_color   = r_color;
        if (accept) begin
            case (func)
                FUNC_OUTLINE, FUNC_FILL: begin
                    n_ctr_col = i_item.center_col;
                    n_ctr_row = i_item.center_row;
                    n_color   = i_item.color;
                    n_fill    = (func == FUNC_FILL);
                    n_step_x  = '0;
                    n_step_y  = $signed({2'b00, i_item.radius});
                    n_dec     = 14'sd3 - $signed({4'b0000, i_item.radius, 1'b0});
                end
                FUNC_STEP: begin
                    if (!ended) begin
                        if (r_dec < 0) begin
                            n_dec = r_dec + $signed({r_step_x[10], r_step_x, 2'b00})
                                  + 14'sd6;
                        end else begin
                            n_dec = r_dec + $signed({r_step_x[10], r_step_x, 2'b00})
                                  - $signed({r_step_y[10], r_step_y, 2'b00}) + 14'sd10;
                            n_step_y = r_step_y - 11'sd1;
                        end
                        n_step_x = r_step_x + 11'sd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_push    = accept && (func == FUNC_STEP);
        o_job.xc    = r_ctr_col;
        o_job.yc    = r_ctr_row;
        o_job.x     = r_step_x;
        o_job.y     = r_step_y;
        o_job.color = r_color;
        if (ended) begin
            o_job.kind = JOB_DONE;
            o_job.done = 1'b1;
        end else begin
            o_job.kind = r_fill ? JOB_FILL : JOB_OUTLINE;
            o_job.done = n_step_x > n_step_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr_col <= '0;
            r_ctr_row <= '0;
            r_step_x  <= 11'sd1;
            r_step_y  <= '0;
            r_dec     <= '0;
            r_fill    <= 1'b0;
            r_color   <= '0;
        end else begin
            r_ctr_col <= n_ctr_col;
            r_ctr_row <= n_ctr_row;
            r_step_x  <= n_step_x;
            r_step_y  <= n_step_y;
            r_dec     <= n_dec;
            r_fill    <= n_fill;
            r_color   <= n_color;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mcsr_queue.sv =====
// Short job queue between the front end and the span generator.
// Depends on mcsr_pkg for the job type and depth.
`default_nettype none
module mcsr_queue import mcsr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_job   i_job,
    input  wire logic   i_pop,
    output t_job        o_head,
    output t_q_stat     o_stat
);

    t_job                 r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]     r_cnt;
    logic [Q_PTR_W-1:0]   n_wr_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]     n_cnt;
    logic                 do_push, do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == (Q_PTR_W)'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == (Q_PTR_W)'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mcsr_back.sv =====
// Span generator: walks the slots of the head job, clips each span to the
// scissor box and registers it for the span channel. Depends on mcsr_pkg.
`default_nettype none
module mcsr_back import mcsr_pkg::*; #(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 240
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_job                  i_head,
    input  wire t_q_stat               i_stat,
    output logic                       o_pop,
    mcsr_span_if.source                o_span
);

    localparam int CW = 13;
    localparam logic signed [CW-1:0] W_LIM = CW'(SCREEN_W);
    localparam logic signed [CW-1:0] H_LIM = CW'(SCREEN_H);

    logic [8:0] r_left, r_right;
    logic [7:0] r_top, r_bottom;

    logic [2:0] r_slot, n_slot, last_idx;
    logic       r_valid, n_valid;
    logic       r_vis, r_done, r_last;
    logic [7:0] r_row, r_color;
    logic [8:0] r_cs, r_ce;

    logic                 load, is_last, vis;
    logic signed [CW-1:0] xc, yc, xx, yy, row, c0, c1, ca, cb;
    logic signed [CW-1:0] lim_l, lim_r, lim_t, lim_b;

    function automatic logic signed [CW-1:0] sx(input logic signed [10:0] v);
        return {{(CW-11){v[10]}}, v};
    endfunction

    always_comb begin
        lim_l = ({{(CW-9){1'b0}}, r_left} > W_LIM) ? W_LIM : {{(CW-9){1'b0}}, r_left};
        lim_r = ({{(CW-9){1'b0}}, r_right} > W_LIM) ? W_LIM : {{(CW-9){1'b0}}, r_right};
        lim_t = ({{(CW-8){1'b0}}, r_top} > H_LIM) ? H_LIM : {{(CW-8){1'b0}}, r_top};
        lim_b = ({{(CW-8){1'b0}}, r_bottom} > H_LIM) ? H_LIM
              : {{(CW-8){1'b0}}, r_bottom};
    end

    always_comb begin
        xc = sx(i_head.xc);
        yc = sx(i_head.yc);
        xx = sx(i_head.x);
        yy = sx(i_head.y);
        row = '0;
        c0  = '0;
        c1  = '0;
        case (i_head.kind)
            JOB_OUTLINE: begin
                last_idx = 3'd7;
                case (r_slot)
                    3'd0: begin row = yc + yy; c0 = xc + xx; end
                    3'd1: begin row = yc + yy; c0 = xc - xx; end
                    3'd2: begin row = yc - yy; c0 = xc + xx; end
                    3'd3: begin row = yc - yy; c0 = xc - xx; end
                    3'd4: begin row = yc + xx; c0 = xc + yy; end
                    3'd5: begin row = yc + xx; c0 = xc - yy; end
                    3'd6: begin row = yc - xx; c0 = xc + yy; end
                    default: begin row = yc - xx; c0 = xc - yy; end
                endcase
                c1 = c0 + CW'(1);
            end
            JOB_FILL: begin
                last_idx = 3'd3;
                case (r_slot)
                    3'd0: begin row = yc - yy; c0 = xc - xx; c1 = xc + xx + CW'(1); end
                    3'd1: begin row = yc + yy; c0 = xc - xx; c1 = xc + xx + CW'(1); end
                    3'd2: begin row = yc - xx; c0 = xc - yy; c1 = xc + yy + CW'(1); end
                    default: begin row = yc + xx; c0 = xc - yy; c1 = xc + yy + CW'(1); end
                endcase
            end
            default: begin
                last_idx = 3'd0;
            end
        endcase
        ca  = (c0 < lim_l) ? lim_l : c0;
        cb  = (c1 > lim_r) ? lim_r : c1;
        vis = (i_head.kind != JOB_DONE) && (row >= lim_t) && (row < lim_b) && (ca < cb);
    end

    assign is_last = (r_slot == last_idx);
    assign load    = !i_stat.empty && (!r_valid || o_span.ready);
    assign o_pop   = load && is_last;

    always_comb begin
        n_slot  = r_slot;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_slot  = is_last ? '0 : r_slot + 3'd1;
        end else if (o_span.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_slot  <= n_slot;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_vis   <= vis;
            r_row   <= vis ? row[7:0] : '0;
            r_cs    <= vis ? ca[8:0] : '0;
            r_ce    <= vis ? cb[8:0] : '0;
            r_color <= i_head.color;
            r_done  <= i_head.done;
            r_last  <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= 9'd320;
            r_bottom <= 8'd240;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEFT:   r_left   <= i_cfg_data;
                CFG_TOP:    r_top    <= i_cfg_data[7:0];
                CFG_RIGHT:  r_right  <= i_cfg_data;
                CFG_BOTTOM: r_bottom <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_span.valid       = r_valid;
    assign o_span.visible     = r_vis;
    assign o_span.row         = r_row;
    assign o_span.col_start   = r_cs;
    assign o_span.col_end     = r_ce;
    assign o_span.pix_color   = r_color;
    assign o_span.circle_done = r_done;
    assign o_span.last        = r_last;

endmodule
`default_nettype wire

// ===== rtl/core/midpoint_circle_span_rasterizer.sv =====
// Midpoint circle span rasterizer, top level: front end, job queue, span generator.
// Step jobs go via the two-entry queue, which sets the lead, to the span register.
// Throughput: the span generator gives one span beat per cycle while a job waits
// and the span channel is ready; a step beat gives 8 span beats in outline mode,
// 4 in filled mode, 1 once the circle is done. Start beats give no span.
// Reset: synchronous active low; circle idle and done, scissor 0,0 to 320,240.
`default_nettype none
module midpoint_circle_span_rasterizer import mcsr_pkg::*; #(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 240
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mcsr_item_if.sink                  i_item,
    mcsr_span_if.source                o_span
);

    logic    push, pop;
    t_job    job, head;
    t_q_stat q_stat;

    mcsr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_job    (job)
    );

    mcsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    mcsr_back #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (head),
        .i_stat     (q_stat),
        .o_pop      (pop),
        .o_span     (o_span)
    );

    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (o_span.valid && o_span.last))
        else $error("job retired without a last beat");

    a_invis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_span.valid && !o_span.visible) |->
        (o_span.row == '0 && o_span.col_start == '0 && o_span.col_end == '0))
        else $error("invisible span carries coordinates");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_span.valid)
        else $error("span valid right after reset");

endmodule
`default_nettype wire

// ===== verif/midpoint_circle_span_rasterizer_checker.sv =====
// Span checker for the midpoint circle span rasterizer: watches the scissor
// write port and both channels, predicts every span beat and compares it.
// Depends on mcsr_pkg and the channel interfaces in mcsr_if.sv.
module midpoint_circle_span_rasterizer_checker import mcsr_pkg::*; #(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 240
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mcsr_item_if                  i_item,
    mcsr_span_if                  i_span,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic       visible;
        logic [7:0] row;
        logic [8:0] col_start;
        logic [8:0] col_end;
        logic [7:0] pix_color;
        logic       circle_done;
        logic       last;
    } span_t;

    span_t      expected_spans[$];
    logic [8:0] clip_left;
    logic [8:0] clip_right;
    logic [7:0] clip_top;
    logic [7:0] clip_bottom;
    int         ctr_col;
    int         ctr_row;
    int         cur_x;
    int         cur_y;
    int         decision;
    logic       fill_mode;
    logic [7:0] draw_color;
    int         fail_count = 0;
    int         span_beats = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(string msg);
        $display("ERROR span beat %0d: %s", span_beats, msg);
        fail_count++;
    endtask

    task automatic check_field(string field, int got, int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
        end
    endtask

    function automatic span_t clip_span(int r, int c0, int c1, logic done, logic last);
        int    lo_c;
        int    hi_c;
        int    lo_r;
        int    hi_r;
        int    a;
        int    b;
        span_t s;
        lo_c = (int'(clip_left) > SCREEN_W) ? SCREEN_W : int'(clip_left);
        hi_c = (int'(clip_right) > SCREEN_W) ? SCREEN_W : int'(clip_right);
        lo_r = (int'(clip_top) > SCREEN_H) ? SCREEN_H : int'(clip_top);
        hi_r = (int'(clip_bottom) > SCREEN_H) ? SCREEN_H : int'(clip_bottom);
        a = (c0 < lo_c) ? lo_c : c0;
        b = (c1 > hi_c) ? hi_c : c1;
        s = '0;
        s.visible = (r >= lo_r) && (r < hi_r) && (a < b);
        if (s.visible) begin
            s.row = r[7:0];
            s.col_start = a[8:0];
            s.col_end = b[8:0];
        end
        s.pix_color = draw_color;
        s.circle_done = done;
        s.last = last;
        return s;
    endfunction

    task automatic rasterize_beat(t_func func, int col, int row, int rad, logic [7:0] color);
        int    x;
        int    y;
        int    ny;
        logic  done;
        span_t s;
        case (func)
            FUNC_OUTLINE, FUNC_FILL: begin
                ctr_col = col;
                ctr_row = row;
                draw_color = color;
                fill_mode = (func == FUNC_FILL);
                cur_x = 0;
                cur_y = rad;
                decision = 3 - 2 * rad;
            end
            FUNC_STEP: begin
                x = cur_x;
                y = cur_y;
                if (x > y) begin
                    s = '0;
                    s.pix_color = draw_color;
                    s.circle_done = 1'b1;
                    s.last = 1'b1;
                    expected_spans.push_back(s);
                end else begin
                    ny = y;
                    if (decision < 0) begin
                        decision = decision + 4 * x + 6;
                    end else begin
                        decision = decision + 4 * (x - y) + 10;
                        ny = y - 1;
                    end
                    cur_x = x + 1;
                    cur_y = ny;
                    done = (cur_x > cur_y);
                    if (fill_mode) begin
                        expected_spans.push_back(clip_span(ctr_row - y, ctr_col - x,
                                                           ctr_col + x + 1, done, 1'b0));
                        expected_spans.push_back(clip_span(ctr_row + y, ctr_col - x,
                                                           ctr_col + x + 1, done, 1'b0));
                        expected_spans.push_back(clip_span(ctr_row - x, ctr_col - y,
                                                           ctr_col + y + 1, done, 1'b0));
                        expected_spans.push_back(clip_span(ctr_row + x, ctr_col - y,
                                                           ctr_col + y + 1, done, 1'b1));
                    end else begin
                        expected_spans.push_back(clip_span(ctr_row + y, ctr_col + x,
                                                           ctr_col + x + 1, done, 1'b0));
                        expected_spans.push_back(clip_span(ctr_row + y, ctr_col - x,
                                                           ctr_col - x + 1, done, 1'b0));
                        expected_spans.push_back(clip_span(ctr_row - y, ctr_col + x,
                                                           ctr_col + x + 1, done, 1'b0));
                        expected_spans.push_back(clip_span(ctr_row - y, ctr_col - x,
                                                           ctr_col - x + 1, done, 1'b0));
                        expected_spans.push_back(clip_span(ctr_row + x, ctr_col + y,
                                                           ctr_col + y + 1, done, 1'b0));
                        expected_spans.push_back(clip_span(ctr_row + x, ctr_col - y,
                                                           ctr_col - y + 1, done, 1'b0));
                        expected_spans.push_back(clip_span(ctr_row - x, ctr_col + y,
                                                           ctr_col + y + 1, done, 1'b0));
                        expected_spans.push_back(clip_span(ctr_row - x, ctr_col - y,
                                                           ctr_col - y + 1, done, 1'b1));
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        span_t got;
        span_t want;
        if (!i_rst_n) begin
            expected_spans.delete();
            clip_left = 9'd0;
            clip_top = 8'd0;
            clip_right = 9'd320;
            clip_bottom = 8'd240;
            ctr_col = 0;
            ctr_row = 0;
            cur_x = 1;
            cur_y = 0;
            decision = 0;
            fill_mode = 1'b0;
            draw_color = 8'd0;
            o_pending <= 0;
        end else begin
            if (i_span.valid && i_span.ready) begin
                got = {i_span.visible, i_span.row, i_span.col_start, i_span.col_end,
                       i_span.pix_color, i_span.circle_done, i_span.last};
                if (expected_spans.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat %h", got));
                end else begin
                    want = expected_spans.pop_front();
                    check_field("visible", got.visible, want.visible);
                    check_field("row", got.row, want.row);
                    check_field("col_start", got.col_start, want.col_start);
                    check_field("col_end", got.col_end, want.col_end);
                    check_field("pix_color", got.pix_color, want.pix_color);
                    check_field("circle_done", got.circle_done, want.circle_done);
                    check_field("last", got.last, want.last);
                end
                span_beats++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEFT:   clip_left = i_cfg_data[8:0];
                    CFG_TOP:    clip_top = i_cfg_data[7:0];
                    CFG_RIGHT:  clip_right = i_cfg_data[8:0];
                    CFG_BOTTOM: clip_bottom = i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                rasterize_beat(t_func'(i_item.func), int'(i_item.center_col),
                               int'(i_item.center_row), int'(i_item.radius), i_item.color);
            end
            o_pending <= expected_spans.size();
        end
    end

endmodule

// ===== verif/midpoint_circle_span_rasterizer_tb.sv =====
// Testbench top for the midpoint circle span rasterizer: clock, reset, scissor
// writes, circle and step beats, output stalls and the verdict.
// Depends on mcsr_pkg, mcsr_if.sv, the block and the span checker.
module midpoint_circle_span_rasterizer_tb;
    import mcsr_pkg::*;

    localparam int SCREEN_W = 320;
    localparam int SCREEN_H = 240;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending_n;
    int                    send_idle_pct;
    int                    stall_pct;
    int                    items_sent;

    mcsr_item_if item_ch();
    mcsr_span_if span_ch();

    midpoint_circle_span_rasterizer #(
        .SCREEN_W(SCREEN_W),
        .SCREEN_H(SCREEN_H)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data),
        .i_item(item_ch),
        .o_span(span_ch)
    );

    midpoint_circle_span_rasterizer_checker #(
        .SCREEN_W(SCREEN_W),
        .SCREEN_H(SCREEN_H)
    ) span_check (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data),
        .i_item(item_ch),
        .i_span(span_ch),
        .o_fail_count(fail_count),
        .o_pending(pending_n)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        span_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic set_scissor(int left, int top, int right, int bottom);
        write_reg(CFG_LEFT, left);
        write_reg(CFG_TOP, top);
        write_reg(CFG_RIGHT, right);
        write_reg(CFG_BOTTOM, bottom);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(t_func func, int col, int row, int rad, int color);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.func <= func;
        item_ch.center_col <= 11'(col);
        item_ch.center_row <= 11'(row);
        item_ch.radius <= 9'(rad);
        item_ch.color <= 8'(color);
        do @(posedge clk); while (!item_ch.ready);
        if (func != FUNC_IGNORE) begin
            items_sent++;
        end
    endtask

    task automatic send_step();
        send_item(FUNC_STEP, $urandom, $urandom, $urandom, $urandom);
    endtask

    // drop valid, drain all expected beats, then let the queue settle
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_n != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic run_circle();
        int pick;
        int rad;
        int steps;
        int col;
        int row;
        pick = $urandom_range(99);
        if (pick < 80) begin
            rad = $urandom_range(0, 24);
        end else if (pick < 95) begin
            rad = $urandom_range(25, 90);
        end else begin
            rad = $urandom_range(91, 511);
        end
        if ($urandom_range(99) < 85) begin
            col = int'($urandom_range(0, 400)) - 40;
            row = int'($urandom_range(0, 320)) - 40;
        end else begin
            col = $urandom;
            row = $urandom;
        end
        steps = rad * 717 / 1000 + 1 + $urandom_range(0, 2);
        if (rad > 90) begin
            steps = $urandom_range(1, 30);
        end else if ($urandom_range(99) < 10) begin
            steps = $urandom_range(0, steps);
        end
        send_item($urandom_range(1) ? FUNC_FILL : FUNC_OUTLINE, col, row, rad, $urandom);
        repeat (steps) begin
            if ($urandom_range(99) < 8) begin
                send_item(FUNC_IGNORE, $urandom, $urandom, $urandom, $urandom);
            end
            send_step();
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_LEFT;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.func = FUNC_STEP;
        item_ch.center_col = '0;
        item_ch.center_row = '0;
        item_ch.radius = '0;
        item_ch.color = '0;
        span_ch.ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_scissor(0, 0, SCREEN_W, SCREEN_H);
        send_step();
        send_item(FUNC_IGNORE, 0, 0, 0, 0);
        send_item(FUNC_OUTLINE, 0, 0, 0, 255);
        send_step();
        send_step();
        send_item(FUNC_FILL, 319, 239, 1, 1);
        send_step();
        send_step();
        send_item(FUNC_OUTLINE, -1024, 1023, 511, 170);
        send_step();
        send_step();
        send_item(FUNC_FILL, 160, 120, 511, 85);
        send_step();
        send_step();
        send_item(FUNC_OUTLINE, 1023, -1024, 5, 0);
        send_step();
        send_item(FUNC_FILL, 3, 236, 7, 200);
        repeat (7) send_step();

        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            case (phase / 2)
                0: begin
                    send_idle_pct = 10;
                    stall_pct <= 54;
                end
                1: begin
                    send_idle_pct = 54;
                    stall_pct <= 10;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct <= 0;
                end
            endcase
            case (phase)
                0: set_scissor(0, 0, SCREEN_W, SCREEN_H);
                1: set_scissor($urandom_range(0, 160), $urandom_range(0, 120),
                               $urandom_range(160, 320), $urandom_range(120, 240));
                2: set_scissor($urandom_range(0, 40), $urandom_range(0, 40), 511, 255);
                3: set_scissor(300, 200, 0, 0);
                4: set_scissor($urandom_range(0, 320), $urandom_range(0, 240),
                               $urandom_range(0, 320), $urandom_range(0, 240));
                default: set_scissor(511, 255, 511, 255);
            endcase
            items_sent = 0;
            while (items_sent < 62) begin
                run_circle();
            end
        end

        wait_idle();
        if (fail_count == 0 && pending_n == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
